// ===== hw/rtl/ttfs_pkg.sv =====
// ttfs_pkg: shared types, codes and helpers for the ramp neuron soma
`timescale 1ns / 1ps
`default_nettype none

package ttfs_pkg;

    // field widths fixed by the item format
    localparam int ADDR_W  = 10;
    localparam int PARAM_W = 32;
    localparam int POT_W   = 48;
    localparam int CYC_W   = 34;

    // input item kind carried in tuser
    localparam logic CMD_STEP  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_UPDATED = 2'd1,
        ST_FIRED   = 2'd2,
        ST_WRITTEN = 2'd3
    } status_t;

    // parameter selector for write items
    typedef enum logic [1:0] {
        PSEL_THRESHOLD = 2'd0,
        PSEL_BIAS      = 2'd1,
        PSEL_WIN_START = 2'd2,
        PSEL_WIN_LEN   = 2'd3
    } psel_t;

    // one neuron's stored state
    typedef struct packed {
        logic signed [POT_W-1:0]   membrane;
        logic signed [POT_W-1:0]   ramp;
        logic signed [PARAM_W-1:0] threshold;
        logic signed [PARAM_W-1:0] bias;
        logic signed [PARAM_W-1:0] win_start;
        logic signed [PARAM_W-1:0] win_length;
        logic                      spiked;
    } ttfs_word_t;

    // clamp a 50-bit sum to the signed 48-bit range
    function automatic logic signed [POT_W-1:0] sat48(input logic signed [POT_W+1:0] v);
        logic signed [POT_W-1:0] r;
        r = v[POT_W-1:0];
        if (v[POT_W+1] == 1'b0 && v[POT_W:POT_W-1] != 2'b00)
        begin
            r = {1'b0, {(POT_W-1){1'b1}}};
        end
        else if (v[POT_W+1] == 1'b1 && v[POT_W:POT_W-1] != 2'b11)
        begin
            r = {1'b1, {(POT_W-1){1'b0}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ttfs_ramp_neuron_soma.sv =====
// ttfs_ramp_neuron_soma: single-spike ramp integrate-and-fire neuron core
//
//  channel | dir | handshake            | content
//  --------+-----+----------------------+------------------------------------------
//  cfg     | in  | cfg_valid/cfg_ready  | inclusive_mode
//  s_axis  | in  | s_tvalid/s_tready    | step or parameter write for one neuron
//  m_axis  | out | m_tvalid/m_tready    | status, neuron echo, membrane potential
//
//  one item per clock outside the clearing pass and while the output is not stalled; an item's result is registered
//  (state memory read at the transfer edge, one update pass into the output register)
//  back-to-back items on one neuron are served by forwarding the last write
//  after reset a clearing pass writes every neuron, all min(NEURONS, 1024) words,
//  with s_tready low; configuration writes are taken throughout
//  a stalled output holds the update stage, and s_tready follows it
`timescale 1ns / 1ps
`default_nettype none

module ttfs_ramp_neuron_soma #(
    parameter int NEURONS       = 1024,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // configuration
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic         cfg_data,       // inclusive_mode
    // input items
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [111:0] s_tdata,        // neuron, current, timestep, param_value
    input  wire logic [3:0]   s_tuser,        // cmd, current_present, param_select
    // result items
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata,        // neuron_echo, potential
    output logic [1:0]        m_tuser         // status
);
    import ttfs_pkg::*;

    localparam int DEPTH = (NEURONS < (1 << ADDR_W)) ? NEURONS : (1 << ADDR_W);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic signed [PARAM_W-1:0] THRESH_RESET =
        PARAM_W'(64'd1 << FRACTION_BITS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    // input field unpacking
    logic                      in_cmd;
    logic                      in_present;
    psel_t                     in_sel;
    logic [ADDR_W-1:0]         in_neuron;
    logic signed [PARAM_W-1:0] in_current;
    logic [PARAM_W-1:0]        in_timestep;
    logic signed [PARAM_W-1:0] in_value;
    logic                      in_range;
    logic [AW-1:0]             in_addr;
    logic signed [CYC_W-1:0]   in_cycle;

    assign in_cmd      = s_tuser[0];
    assign in_present  = s_tuser[1];
    assign in_sel      = psel_t'(s_tuser[3:2]);
    assign in_neuron   = s_tdata[9:0];
    assign in_current  = s_tdata[41:10];
    assign in_timestep = s_tdata[73:42];
    assign in_value    = s_tdata[105:74];
    assign in_range    = (32'(in_neuron) < 32'(NEURONS));
    assign in_addr     = in_range ? in_neuron[AW-1:0] : '0;
    assign in_cycle    = {2'b00, in_timestep} - CYC_W'(1);

    // control and datapath registers
    logic                      clr_active_reg;
    logic [AW-1:0]             clr_addr_reg;
    logic                      incl_reg;
    logic                      s1_valid_reg;
    logic                      s1_cmd_reg;
    logic                      s1_present_reg;
    psel_t                     s1_sel_reg;
    logic [ADDR_W-1:0]         s1_neuron_reg;
    logic                      s1_range_reg;
    logic [AW-1:0]             s1_addr_reg;
    logic signed [PARAM_W-1:0] s1_current_reg;
    logic signed [CYC_W-1:0]   s1_cycle_reg;
    logic signed [PARAM_W-1:0] s1_value_reg;
    ttfs_word_t                rd_word_reg;
    logic                      wb_valid_reg;
    logic [AW-1:0]             wb_addr_reg;
    ttfs_word_t                wb_word_reg;
    logic                      m_valid_reg;
    logic [63:0]               m_data_reg;
    status_t                   m_status_reg;

    ttfs_word_t mem [DEPTH];

    logic in_xfer;
    logic advance;

    assign cfg_ready = 1'b1;
    assign advance   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !clr_active_reg && (!s1_valid_reg || advance);
    assign in_xfer   = s_tvalid && s_tready;

    // word currently stored for the item in the update stage
    ttfs_word_t cur_word;
    assign cur_word = (wb_valid_reg && wb_addr_reg == s1_addr_reg) ? wb_word_reg : rd_word_reg;

    // update pass
    logic signed [CYC_W-1:0]   win_lo;
    logic signed [CYC_W-1:0]   win_hi;
    logic                      win_en;
    logic                      outside;
    logic signed [POT_W:0]     ramp_sum;
    logic signed [POT_W-1:0]   ramp_new;
    logic signed [POT_W+1:0]   pot_sum;
    logic signed [POT_W-1:0]   pot_new;
    logic signed [POT_W-1:0]   thresh_ext;
    logic                      fire;
    ttfs_word_t                new_word;
    status_t                   status_next;
    logic signed [POT_W-1:0]   pot_out;

    always_comb
    begin
        win_lo     = {{2{cur_word.win_start[PARAM_W-1]}}, cur_word.win_start};
        win_hi     = win_lo + {{2{cur_word.win_length[PARAM_W-1]}}, cur_word.win_length};
        win_en     = !cur_word.win_length[PARAM_W-1] && (cur_word.win_length != '0);
        outside    = win_en && ((s1_cycle_reg < win_lo) || (s1_cycle_reg >= win_hi));
        ramp_sum   = {cur_word.ramp[POT_W-1], cur_word.ramp}
                   + {{(POT_W+1-PARAM_W){s1_current_reg[PARAM_W-1]}}, s1_current_reg};
        ramp_new   = s1_present_reg ? sat48({ramp_sum[POT_W], ramp_sum}) : cur_word.ramp;
        pot_sum    = {{2{cur_word.membrane[POT_W-1]}}, cur_word.membrane}
                   + {{2{ramp_new[POT_W-1]}}, ramp_new}
                   + {{(POT_W+2-PARAM_W){cur_word.bias[PARAM_W-1]}}, cur_word.bias};
        pot_new    = sat48(pot_sum);
        thresh_ext = {{(POT_W-PARAM_W){cur_word.threshold[PARAM_W-1]}}, cur_word.threshold};
        fire       = !cur_word.spiked &&
                     (incl_reg ? (pot_new >= thresh_ext) : (pot_new > thresh_ext));
        new_word   = cur_word;
        status_next = ST_IDLE;
        if (!s1_range_reg)
        begin
            status_next = (s1_cmd_reg == CMD_WRITE) ? ST_WRITTEN : ST_IDLE;
        end
        else if (s1_cmd_reg == CMD_WRITE)
        begin
            status_next = ST_WRITTEN;
            unique case (s1_sel_reg)
                PSEL_THRESHOLD: new_word.threshold  = s1_value_reg;
                PSEL_BIAS:      new_word.bias       = s1_value_reg;
                PSEL_WIN_START: new_word.win_start  = s1_value_reg;
                PSEL_WIN_LEN:   new_word.win_length = s1_value_reg;
                default:        new_word.win_length = s1_value_reg;
            endcase
        end
        else if (!outside)
        begin
            new_word.ramp     = ramp_new;
            new_word.membrane = pot_new;
            status_next       = ST_UPDATED;
            if (fire)
            begin
                new_word.spiked = 1'b1;
                status_next     = ST_FIRED;
            end
        end
        pot_out = s1_range_reg ? new_word.membrane : '0;
    end

    // reset word for the clearing pass
    ttfs_word_t reset_word;
    always_comb
    begin
        reset_word            = '0;
        reset_word.threshold  = THRESH_RESET;
    end

    // state memory: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            mem[clr_addr_reg] <= reset_word;
        end
        else if (advance && s1_range_reg)
        begin
            mem[s1_addr_reg] <= new_word;
        end
        if (in_xfer)
        begin
            rd_word_reg <= mem[in_addr];
        end
    end

    // clearing pass, configuration and valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            incl_reg       <= 1'b1;
            s1_valid_reg   <= 1'b0;
            wb_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                incl_reg <= cfg_data;
            end
            if (in_xfer)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance && s1_range_reg)
            begin
                wb_valid_reg <= 1'b1;
            end
            if (advance)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_cmd_reg     <= in_cmd;
            s1_present_reg <= in_present;
            s1_sel_reg     <= in_sel;
            s1_neuron_reg  <= in_neuron;
            s1_range_reg   <= in_range;
            s1_addr_reg    <= in_addr;
            s1_current_reg <= in_current;
            s1_cycle_reg   <= in_cycle;
            s1_value_reg   <= in_value;
        end
        if (advance && s1_range_reg)
        begin
            wb_addr_reg <= s1_addr_reg;
            wb_word_reg <= new_word;
        end
        if (advance)
        begin
            m_data_reg   <= {6'b000000, pot_out, s1_neuron_reg};
            m_status_reg <= status_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

    // checks
    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !s_tready)
        else $error("input transfer allowed during clearing pass");

    a_clear_runs_once: assert property (@(posedge clk) disable iff (!rst_n)
        !clr_active_reg |=> !clr_active_reg)
        else $error("clearing pass restarted");

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_valid_reg)
        else $error("update stage moved without filling output register");

    a_write_status: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_cmd_reg == CMD_WRITE) |=> (m_status_reg == ST_WRITTEN))
        else $error("write item did not report written status");

    a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && 32'(m_data_reg[9:0]) >= 32'(NEURONS)) |-> (m_data_reg[57:10] == '0))
        else $error("unmapped neuron reported nonzero potential");

endmodule

`default_nettype wire
